[sv/led_matrix_pixel_spi_encoder_top_macros.svh]
// Assertion macros for the LED matrix pixel SPI encoder.
// Included by the top level, which carries the concurrent checks; no other dependencies.
`ifndef LED_MATRIX_PIXEL_SPI_ENCODER_TOP_MACROS_SVH
`define LED_MATRIX_PIXEL_SPI_ENCODER_TOP_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted
`define LMPSE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted
`define LMPSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define LMPSE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define LMPSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[sv/lmpse_pkg.sv]
// Shared types and constants for the LED matrix pixel SPI encoder.
// No dependencies; used by lmpse_beat_enc and the top level.
package lmpse_pkg;

  localparam int unsigned MaxChipsDefault = 64;

  localparam int unsigned ColourW  = 8;
  localparam int unsigned ChipW    = 6;
  localparam int unsigned CoordW   = 3;
  localparam int unsigned OffsetW  = 16;
  localparam int unsigned SpiW     = 24;
  localparam int unsigned BeatW    = 2;
  localparam int unsigned PaddrW   = 4;
  localparam int unsigned PdataW   = 32;

  // Colour beats within one pixel
  localparam logic [BeatW-1:0] BeatFirst  = 2'd0;
  localparam logic [BeatW-1:0] BeatSecond = 2'd1;
  localparam logic [BeatW-1:0] BeatLast   = 2'd2;

  // SPI symbols for one colour bit
  localparam logic [2:0] SpiOne  = 3'b110;
  localparam logic [2:0] SpiZero = 3'b100;

  // Register indexes (byte address / 4)
  localparam logic [1:0] RegBrightness  = 2'd0;
  localparam logic [1:0] RegColorOrder  = 2'd1;
  localparam logic [1:0] RegPixelLayout = 2'd2;

  typedef struct packed {
    logic [ColourW-1:0] red;
    logic [ColourW-1:0] green;
    logic [ColourW-1:0] blue;
    logic [ChipW-1:0]   chip_index;
    logic [CoordW-1:0]  pixel_column;
    logic [CoordW-1:0]  pixel_row;
  } pix_in_t;

  typedef struct packed {
    logic [OffsetW-1:0] byte_offset;
    logic [SpiW-1:0]    encoded_bits;
    logic               last_of_pixel;
  } pix_out_t;

  // Pixel as held between input and result registers
  typedef struct packed {
    logic [ColourW-1:0] red;
    logic [ColourW-1:0] green;
    logic [ColourW-1:0] blue;
    logic [OffsetW-1:0] base_offset;
  } pix_hold_t;

endpackage

[sv/lmpse_beat_enc.sv]
// Per-beat colour encoder: pick a colour, scale by brightness, expand to SPI bits.
// Depends on lmpse_pkg.
module lmpse_beat_enc (
  input  lmpse_pkg::pix_hold_t       pix_i,
  input  logic [lmpse_pkg::BeatW-1:0] beat_i,
  input  logic [lmpse_pkg::ColourW-1:0] brightness_i,
  input  logic                       color_order_i,
  output lmpse_pkg::pix_out_t        res_o
);
  import lmpse_pkg::*;

  logic [ColourW-1:0] colour;
  logic [15:0]        product;
  logic [16:0]        corr_sum;
  logic [ColourW-1:0] scaled;
  logic [SpiW-1:0]    spi;
  logic [OffsetW-1:0] step;

  // Select the colour for this beat in wire order
  always_comb begin
    unique case (beat_i)
      BeatFirst:  colour = color_order_i ? pix_i.green : pix_i.red;
      BeatSecond: colour = color_order_i ? pix_i.red : pix_i.green;
      default:    colour = pix_i.blue;
    endcase
  end

  // Scale and divide by 255: floor(x/255) = (x + (x >> 8) + 1) >> 8 for 16-bit x
  always_comb begin
    product  = 16'(colour) * 16'(brightness_i);
    corr_sum = 17'(product) + 17'(product[15:8]) + 17'd1;
    scaled   = corr_sum[15:8];
  end

  // Expand each bit to a three-bit symbol, MSB first
  always_comb begin
    for (int i = 0; i < ColourW; i++) begin
      spi[3*i +: 3] = scaled[i] ? SpiOne : SpiZero;
    end
  end

  // Offset advances by three bytes per colour
  assign step = 16'({beat_i, 1'b0}) + 16'(beat_i);

  always_comb begin
    res_o.byte_offset   = pix_i.base_offset + step;
    res_o.encoded_bits  = spi;
    res_o.last_of_pixel = (beat_i == BeatLast);
  end

endmodule

[sv/led_matrix_pixel_spi_encoder_top.sv]
// Flow: an accepted pixel is held in the hold register; its first colour transfer is offered
// from the result register, and the other two follow when the output is not stalled.
// Throughput: set by the single scaling multiplier and result register, which emit
// one colour per cycle when the output is not stalled; the next pixel is taken
// at the edge at which the last colour enters the result register.
// Reset: clears valid flags and beat count; brightness 255, GRB order, serpentine.
`include "led_matrix_pixel_spi_encoder_top_macros.svh"

module led_matrix_pixel_spi_encoder_top #(
  parameter int unsigned MaxChips = lmpse_pkg::MaxChipsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  lmpse_pkg::pix_in_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output lmpse_pkg::pix_out_t               out_data_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lmpse_pkg::PaddrW-1:0]      paddr,
  input  logic [lmpse_pkg::PdataW-1:0]      pwdata,
  output logic [lmpse_pkg::PdataW-1:0]      prdata,
  output logic                              pready
);
  import lmpse_pkg::*;

  logic [ColourW-1:0] brightness_q;
  logic               color_order_q;
  logic               pixel_layout_q;
  logic               cfg_wr;
  logic [1:0]         cfg_idx;

  logic               hold_valid_q, hold_valid_d;
  pix_hold_t          hold_q, hold_d;
  logic [BeatW-1:0]   beat_q, beat_d;
  logic               out_valid_q, out_valid_d;
  pix_out_t           out_data_q;
  pix_out_t           beat_res;

  logic               out_free;
  logic               adv;
  logic               hold_done;
  logic               in_xfer;
  logic               chip_ok;
  logic [CoordW-1:0]  col_eff;
  logic [11:0]        pixel_idx;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brightness_q   <= 8'd255;
      color_order_q  <= 1'b1;
      pixel_layout_q <= 1'b1;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegBrightness:  brightness_q   <= pwdata[ColourW-1:0];
        RegColorOrder:  color_order_q  <= pwdata[0];
        RegPixelLayout: pixel_layout_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      RegBrightness:  prdata = PdataW'(brightness_q);
      RegColorOrder:  prdata = PdataW'(color_order_q);
      RegPixelLayout: prdata = PdataW'(pixel_layout_q);
      default:        prdata = '0;
    endcase
  end

  // Handshake control
  assign out_free   = !out_valid_q || !out_stall_i;
  assign adv        = hold_valid_q && out_free;
  assign hold_done  = adv && (beat_q == BeatLast);
  assign in_stall_o = hold_valid_q && !hold_done;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign chip_ok    = (32'(in_data_i.chip_index) < MaxChips);

  // Position in the chain; serpentine reverses odd rows
  assign col_eff   = (pixel_layout_q && in_data_i.pixel_row[0]) ?
                     ~in_data_i.pixel_column : in_data_i.pixel_column;
  assign pixel_idx = {in_data_i.chip_index, in_data_i.pixel_row, col_eff};

  always_comb begin
    hold_d.red         = in_data_i.red;
    hold_d.green       = in_data_i.green;
    hold_d.blue        = in_data_i.blue;
    hold_d.base_offset = 16'({pixel_idx, 3'b000}) + 16'(pixel_idx);
  end

  // Next state of the hold stage and beat counter
  always_comb begin
    hold_valid_d = hold_valid_q;
    if (in_xfer) begin
      hold_valid_d = chip_ok;
    end else if (hold_done) begin
      hold_valid_d = 1'b0;
    end
    beat_d = beat_q;
    if (hold_done) begin
      beat_d = BeatFirst;
    end else if (adv) begin
      beat_d = beat_q + 2'd1;
    end
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      beat_q       <= BeatFirst;
      out_valid_q  <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
      beat_q       <= beat_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Hold payload and result register
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      hold_q <= hold_d;
    end
    if (adv) begin
      out_data_q <= beat_res;
    end
  end

  lmpse_beat_enc u_beat_enc (
    .pix_i         (hold_q),
    .beat_i        (beat_q),
    .brightness_i  (brightness_q),
    .color_order_i (color_order_q),
    .res_o         (beat_res)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Checks
  `LMPSE_ASSERT_IMPL(a_beat_range, clk_i, rst_ni, 1'b1, beat_q != 2'd3)
  `LMPSE_ASSERT_IMPL(a_empty_no_stall, clk_i, rst_ni, !hold_valid_q, !in_stall_o)
  `LMPSE_ASSERT_NEXT(a_last_flag, clk_i, rst_ni, hold_done, out_data_q.last_of_pixel)
  `LMPSE_ASSERT_NEXT(a_hold_stable, clk_i, rst_ni, hold_valid_q && !adv, $stable(hold_q))

endmodule
